// ----- rtl/iir4_pkg.sv -----
`default_nettype none

package iir4_pkg;

    localparam int DEF_SAMPLE_BITS = 12;
    localparam int DEF_FRAC_BITS   = 16;

    localparam int COEF_BITS   = 20;
    localparam int Y_BITS      = 32;
    localparam int CFG_DATA_W  = 2 * COEF_BITS;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_B0_B1 = 3'd0,
        CFG_B2_B3 = 3'd1,
        CFG_B4_A1 = 3'd2,
        CFG_A2_A3 = 3'd3,
        CFG_A4    = 3'd4
    } cfg_reg_t;

    localparam logic [CFG_DATA_W-1:0] RST_B0_B1 = 40'd1841299895;
    localparam logic [CFG_DATA_W-1:0] RST_B2_B3 = 40'd1841302091;
    localparam logic [CFG_DATA_W-1:0] RST_B4_A1 = 40'd936680358327;
    localparam logic [CFG_DATA_W-1:0] RST_A2_A3 = 40'd1027033157730;
    localparam logic [COEF_BITS-1:0]  RST_A4    = 20'd12281;

    typedef struct packed {
        logic [COEF_BITS-1:0] b0;
        logic [COEF_BITS-1:0] b1;
        logic [COEF_BITS-1:0] b2;
        logic [COEF_BITS-1:0] b3;
        logic [COEF_BITS-1:0] b4;
        logic [COEF_BITS-1:0] a1;
        logic [COEF_BITS-1:0] a2;
        logic [COEF_BITS-1:0] a3;
        logic [COEF_BITS-1:0] a4;
    } coef_set_t;

endpackage

`default_nettype wire

// ----- rtl/iir_order4_sample_filter_top.sv -----
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata: sample
// m_        out  m_tvalid/m_tready  m_tdata: out_code, m_tuser: clipped
// cfg_      in   cfg_wr_en          cfg_index, cfg_data (coefficient registers)
//
// one item per cycle sustained while m_tready stays high; the result is registered once the output is free
// input register -> nine multiplies, sum, floor and saturate -> result register
// the output feedback loop closes in that one combinational pass
// rst_n clears handshake state and the input and output history
// a stalled result holds while one more item waits in the input register

`default_nettype none

module iir_order4_sample_filter_top
    import iir4_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // sample
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]         m_tdata,   // out_code
    output logic                                     m_tuser,   // clipped
    input  wire logic                                cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]              cfg_index,
    input  wire logic [CFG_DATA_W-1:0]               cfg_data
);

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    coef_set_t              coef;
    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SAMPLE_BITS-1:0] out_code_reg;
    logic                   clipped_reg;
    logic [SAMPLE_BITS-1:0] code_calc;
    logic                   clip_calc;
    logic                   s_accept;
    logic                   step;

    iir4_coef_regs u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    iir4_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .sample   (sample_reg),
        .coef     (coef),
        .out_code (code_calc),
        .clipped  (clip_calc)
    );

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
        if (step)
        begin
            out_code_reg <= code_calc;
            clipped_reg  <= clip_calc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_code_reg);
    assign m_tuser  = clipped_reg;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input register empty but not ready");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |=> (in_valid_reg && out_valid_reg))
        else $error("item dropped during output stall");

    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("computed item not registered");

    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && clipped_reg) |->
            (out_code_reg == '0 || out_code_reg == '1))
        else $error("clipped result not at a rail");

endmodule

`default_nettype wire

// ----- rtl/iir4_coef_regs.sv -----
`default_nettype none

module iir4_coef_regs
    import iir4_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output coef_set_t                   coef
);

    logic [CFG_DATA_W-1:0] b0_b1_reg;
    logic [CFG_DATA_W-1:0] b2_b3_reg;
    logic [CFG_DATA_W-1:0] b4_a1_reg;
    logic [CFG_DATA_W-1:0] a2_a3_reg;
    logic [COEF_BITS-1:0]  a4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_b1_reg <= RST_B0_B1;
            b2_b3_reg <= RST_B2_B3;
            b4_a1_reg <= RST_B4_A1;
            a2_a3_reg <= RST_A2_A3;
            a4_reg    <= RST_A4;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_B0_B1: b0_b1_reg <= cfg_data;
                CFG_B2_B3: b2_b3_reg <= cfg_data;
                CFG_B4_A1: b4_a1_reg <= cfg_data;
                CFG_A2_A3: a2_a3_reg <= cfg_data;
                CFG_A4:    a4_reg    <= cfg_data[COEF_BITS-1:0];
                default:   ;
            endcase
        end
    end

    assign coef.b0 = b0_b1_reg[COEF_BITS-1:0];
    assign coef.b1 = b0_b1_reg[CFG_DATA_W-1:COEF_BITS];
    assign coef.b2 = b2_b3_reg[COEF_BITS-1:0];
    assign coef.b3 = b2_b3_reg[CFG_DATA_W-1:COEF_BITS];
    assign coef.b4 = b4_a1_reg[COEF_BITS-1:0];
    assign coef.a1 = b4_a1_reg[CFG_DATA_W-1:COEF_BITS];
    assign coef.a2 = a2_a3_reg[COEF_BITS-1:0];
    assign coef.a3 = a2_a3_reg[CFG_DATA_W-1:COEF_BITS];
    assign coef.a4 = a4_reg;

endmodule

`default_nettype wire

// ----- rtl/iir4_core.sv -----
`default_nettype none

module iir4_core
    import iir4_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire coef_set_t              coef,
    output logic [SAMPLE_BITS-1:0]      out_code,
    output logic                        clipped
);

    localparam int TAPS  = 5;
    localparam int HIST  = TAPS - 1;
    localparam int PB_W  = COEF_BITS + SAMPLE_BITS;
    localparam int PA_W  = COEF_BITS + Y_BITS;
    localparam int FF_W  = PB_W + 3 + FRAC_BITS;
    localparam int FB_W  = PA_W + 2;
    localparam int ACC_W = ((FF_W > FB_W) ? FF_W : FB_W) + 1;
    localparam int YW_W  = ACC_W - FRAC_BITS;
    localparam int QN_W  = Y_BITS - FRAC_BITS;
    localparam int QW    = ((QN_W > SAMPLE_BITS) ? QN_W : SAMPLE_BITS) + 1;

    logic signed [SAMPLE_BITS-1:0] x_hist_reg [HIST];
    logic signed [Y_BITS-1:0]      y_hist_reg [HIST];

    logic signed [COEF_BITS-1:0]   b_c [TAPS];
    logic signed [COEF_BITS-1:0]   a_c [HIST];
    logic signed [SAMPLE_BITS-1:0] x_cur;
    logic signed [SAMPLE_BITS-1:0] xt [TAPS];
    logic signed [PB_W-1:0]        pb [TAPS];
    logic signed [PA_W-1:0]        pa [HIST];
    logic signed [ACC_W-1:0]       ff_sum;
    logic signed [ACC_W-1:0]       fb_sum;
    logic signed [ACC_W-1:0]       acc;
    logic [YW_W-1:0]               y_wide;
    logic signed [Y_BITS-1:0]      y_sat;
    logic [QW-1:0]                 q_ext;
    logic                          q_ovf;

    assign b_c[0] = coef.b0;
    assign b_c[1] = coef.b1;
    assign b_c[2] = coef.b2;
    assign b_c[3] = coef.b3;
    assign b_c[4] = coef.b4;
    assign a_c[0] = coef.a1;
    assign a_c[1] = coef.a2;
    assign a_c[2] = coef.a3;
    assign a_c[3] = coef.a4;

    // offset binary to two's complement
    assign x_cur = {~sample[SAMPLE_BITS-1], sample[SAMPLE_BITS-2:0]};

    always_comb
    begin
        xt[0] = x_cur;
        for (int k = 0; k < HIST; k++)
        begin
            xt[k+1] = x_hist_reg[k];
        end
        for (int k = 0; k < TAPS; k++)
        begin
            pb[k] = b_c[k] * xt[k];
        end
        for (int k = 0; k < HIST; k++)
        begin
            pa[k] = a_c[k] * y_hist_reg[k];
        end
    end

    always_comb
    begin
        ff_sum = '0;
        fb_sum = '0;
        for (int k = 0; k < TAPS; k++)
        begin
            ff_sum = ff_sum + ACC_W'(pb[k]);
        end
        for (int k = 0; k < HIST; k++)
        begin
            fb_sum = fb_sum + ACC_W'(pa[k]);
        end
        acc = (ff_sum <<< FRAC_BITS) - fb_sum;
    end

    // floor to FRAC_BITS fraction bits, then saturate to the history width
    assign y_wide = acc[ACC_W-1:FRAC_BITS];

    always_comb
    begin
        if (y_wide[YW_W-1:Y_BITS-1] == {(YW_W-Y_BITS+1){y_wide[YW_W-1]}})
        begin
            y_sat = y_wide[Y_BITS-1:0];
        end
        else if (y_wide[YW_W-1])
        begin
            y_sat = {1'b1, {(Y_BITS-1){1'b0}}};
        end
        else
        begin
            y_sat = {1'b0, {(Y_BITS-1){1'b1}}};
        end
    end

    // integer part, then code saturation at both ends
    assign q_ext = {{(QW-QN_W){y_sat[Y_BITS-1]}}, y_sat[Y_BITS-1:FRAC_BITS]};
    assign q_ovf = (q_ext[QW-1:SAMPLE_BITS-1] != {(QW-SAMPLE_BITS+1){q_ext[QW-1]}});

    always_comb
    begin
        if (!q_ovf)
        begin
            out_code = {~q_ext[SAMPLE_BITS-1], q_ext[SAMPLE_BITS-2:0]};
        end
        else if (q_ext[QW-1])
        begin
            out_code = '0;
        end
        else
        begin
            out_code = '1;
        end
    end

    assign clipped = q_ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < HIST; k++)
            begin
                x_hist_reg[k] <= '0;
                y_hist_reg[k] <= '0;
            end
        end
        else if (step)
        begin
            x_hist_reg[0] <= x_cur;
            y_hist_reg[0] <= y_sat;
            for (int k = 1; k < HIST; k++)
            begin
                x_hist_reg[k] <= x_hist_reg[k-1];
                y_hist_reg[k] <= y_hist_reg[k-1];
            end
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/iir4_filter_checker.sv -----
`default_nettype none

module iir4_filter_checker
    import iir4_pkg::*;
#(
    parameter int TDATA_W = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [TDATA_W-1:0]     s_tdata,    // sample
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [TDATA_W-1:0]     m_tdata,    // out_code
    input  wire logic                   m_tuser,    // clipped
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int                          errors,
    output int                          pending
);

    localparam int     SBITS    = DEF_SAMPLE_BITS;
    localparam int     FBITS    = DEF_FRAC_BITS;
    localparam longint MIDSCALE = 64'sd1 <<< (SBITS - 1);
    localparam longint CODE_MAX = (64'sd1 <<< SBITS) - 1;
    localparam longint Y_MAX    = 64'sd2147483647;
    localparam longint Y_MIN    = -64'sd2147483648;

    typedef struct packed {
        logic [SBITS-1:0] code;
        logic             clip;
    } filter_out_t;

    logic [CFG_DATA_W-1:0] reg_b01;
    logic [CFG_DATA_W-1:0] reg_b23;
    logic [CFG_DATA_W-1:0] reg_b4a1;
    logic [CFG_DATA_W-1:0] reg_a23;
    logic [COEF_BITS-1:0]  reg_a4;
    longint                x_hist [4];
    longint                y_hist [4];
    filter_out_t           expected_codes [$];

    always @(posedge clk or negedge rst_n)
    begin : track
        longint      b [5];
        longint      a [5];
        longint      x;
        longint      acc;
        longint      y;
        longint      code;
        filter_out_t want;

        if (!rst_n)
        begin
            reg_b01  = RST_B0_B1;
            reg_b23  = RST_B2_B3;
            reg_b4a1 = RST_B4_A1;
            reg_a23  = RST_A2_A3;
            reg_a4   = RST_A4;
            for (int k = 0; k < 4; k++)
            begin
                x_hist[k] = 0;
                y_hist[k] = 0;
            end
            expected_codes.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_B0_B1: reg_b01  = cfg_data;
                    CFG_B2_B3: reg_b23  = cfg_data;
                    CFG_B4_A1: reg_b4a1 = cfg_data;
                    CFG_A2_A3: reg_a23  = cfg_data;
                    CFG_A4:    reg_a4   = cfg_data[COEF_BITS-1:0];
                    default:   ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                if (expected_codes.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item, out_code %0d clipped %0b",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    want = expected_codes.pop_front();
                    if (m_tdata !== TDATA_W'(want.code))
                    begin
                        errors++;
                        $display("%0t: out_code expected %0d, actual %0d",
                                 $time, want.code, m_tdata);
                    end
                    if (m_tuser !== want.clip)
                    begin
                        errors++;
                        $display("%0t: clipped expected %0b, actual %0b",
                                 $time, want.clip, m_tuser);
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                b[0] = $signed(reg_b01[COEF_BITS-1:0]);
                b[1] = $signed(reg_b01[CFG_DATA_W-1:COEF_BITS]);
                b[2] = $signed(reg_b23[COEF_BITS-1:0]);
                b[3] = $signed(reg_b23[CFG_DATA_W-1:COEF_BITS]);
                b[4] = $signed(reg_b4a1[COEF_BITS-1:0]);
                a[0] = 0;
                a[1] = $signed(reg_b4a1[CFG_DATA_W-1:COEF_BITS]);
                a[2] = $signed(reg_a23[COEF_BITS-1:0]);
                a[3] = $signed(reg_a23[CFG_DATA_W-1:COEF_BITS]);
                a[4] = $signed(reg_a4);

                x = longint'(s_tdata[SBITS-1:0]) - MIDSCALE;

                // feed-forward sum, then align to twice the fraction bits
                acc = b[0] * x;
                for (int k = 0; k < 4; k++)
                    acc += b[k+1] * x_hist[k];
                acc = acc <<< FBITS;
                for (int k = 0; k < 4; k++)
                    acc -= a[k+1] * y_hist[k];

                y = acc >>> FBITS;
                if (y > Y_MAX)
                    y = Y_MAX;
                if (y < Y_MIN)
                    y = Y_MIN;

                for (int k = 3; k > 0; k--)
                begin
                    x_hist[k] = x_hist[k-1];
                    y_hist[k] = y_hist[k-1];
                end
                x_hist[0] = x;
                y_hist[0] = y;

                code = (y >>> FBITS) + MIDSCALE;
                want.clip = 1'b0;
                if (code > CODE_MAX)
                begin
                    code = CODE_MAX;
                    want.clip = 1'b1;
                end
                if (code < 0)
                begin
                    code = 0;
                    want.clip = 1'b1;
                end
                want.code = code[SBITS-1:0];
                expected_codes.push_back(want);
            end

            pending = expected_codes.size();
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none

module tb;
    import iir4_pkg::*;

    localparam int SBITS      = DEF_SAMPLE_BITS;
    localparam int TDATA_W    = ((SBITS + 7) / 8) * 8;
    localparam int SAMPLE_MAX = (1 << SBITS) - 1;
    localparam int SAMPLE_MID = 1 << (SBITS - 1);
    localparam int COEF_MAX   = (1 << (COEF_BITS - 1)) - 1;
    localparam int COEF_MIN   = -(1 << (COEF_BITS - 1));
    localparam int UNITY      = 1 << DEF_FRAC_BITS;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata;    // sample
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_W-1:0]     m_tdata;    // out_code
    logic                   m_tuser;    // clipped
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     errors;
    int                     pending;
    int                     src_idle_pct;
    int                     snk_idle_pct;
    logic [SBITS-1:0]       last_sample;

    iir_order4_sample_filter_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    iir4_filter_checker #(
        .TDATA_W (TDATA_W)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= snk_idle_pct);

    function automatic logic [CFG_DATA_W-1:0] coef_pair(input int lo, input int hi);
        logic [COEF_BITS-1:0] l;
        logic [COEF_BITS-1:0] h;
        l = COEF_BITS'(lo);
        h = COEF_BITS'(hi);
        return {h, l};
    endfunction

    function automatic int rand_coef(input int mag);
        return int'($urandom_range(2 * mag)) - mag;
    endfunction

    function automatic logic [SBITS-1:0] pick_sample(input logic [SBITS-1:0] prev);
        int roll;
        int walk;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        else if (roll < 16)
            return SBITS'(SAMPLE_MAX);
        else if (roll < 50)
        begin
            // slow wander so the filter sees in-band signals too
            walk = int'(prev) + int'($urandom_range(128)) - 64;
            if (walk < 0)
                walk = 0;
            if (walk > SAMPLE_MAX)
                walk = SAMPLE_MAX;
            return SBITS'(walk);
        end
        return SBITS'($urandom_range(SAMPLE_MAX));
    endfunction

    task automatic send_sample(input logic [SBITS-1:0] v);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(v);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        last_sample = v;
        @(negedge clk);
    endtask

    task automatic run_samples(input int n);
        for (int i = 0; i < n; i++)
            send_sample(pick_sample(last_sample));
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    task automatic program_filter(input logic [CFG_DATA_W-1:0] w01,
                                  input logic [CFG_DATA_W-1:0] w23,
                                  input logic [CFG_DATA_W-1:0] w4a1,
                                  input logic [CFG_DATA_W-1:0] wa23,
                                  input logic [COEF_BITS-1:0]  wa4);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        // unmapped indexes must be ignored
        for (int i = int'(CFG_A4) + 1; i < (1 << CFG_INDEX_W); i++)
            write_reg(CFG_INDEX_W'(i), CFG_DATA_W'({$urandom, $urandom}));
        write_reg(CFG_B0_B1, w01);
        write_reg(CFG_B2_B3, w23);
        write_reg(CFG_B4_A1, w4a1);
        write_reg(CFG_A2_A3, wa23);
        // junk above the a4 field must be dropped
        write_reg(CFG_A4, CFG_DATA_W'({$urandom, wa4}));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic program_stable();
        program_filter(coef_pair(rand_coef(16384), rand_coef(16384)),
                       coef_pair(rand_coef(16384), rand_coef(16384)),
                       coef_pair(rand_coef(16384), rand_coef(8192)),
                       coef_pair(rand_coef(8192), rand_coef(8192)),
                       COEF_BITS'(rand_coef(8192)));
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        src_idle_pct = 19;
        snk_idle_pct = 19;
        last_sample  = SBITS'(SAMPLE_MID);
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // reset coefficients: full-scale steps up and down
        send_sample(SBITS'(SAMPLE_MID));
        for (int i = 0; i < 7; i++)
            send_sample(SBITS'(SAMPLE_MAX));
        for (int i = 0; i < 6; i++)
            send_sample('0);
        send_sample(SBITS'(SAMPLE_MID - 1));
        send_sample(SBITS'(SAMPLE_MID + 1));

        // extreme coefficients drive the feedback into the 32-bit rails
        program_filter(coef_pair(COEF_MAX, COEF_MIN), coef_pair(COEF_MIN, COEF_MIN),
                       coef_pair(COEF_MIN, COEF_MIN), coef_pair(COEF_MIN, COEF_MIN),
                       COEF_BITS'(COEF_MIN));
        send_sample(SBITS'(SAMPLE_MAX));
        send_sample('0);
        send_sample(SBITS'(SAMPLE_MAX));
        send_sample('0);
        send_sample(SBITS'(SAMPLE_MID));
        send_sample(SBITS'(SAMPLE_MAX));
        send_sample('0);
        send_sample(SBITS'(1));

        program_filter(RST_B0_B1, RST_B2_B3, RST_B4_A1, RST_A2_A3, RST_A4);
        run_samples(140);

        // pass-through with no idling on either side
        src_idle_pct = 0;
        snk_idle_pct = 0;
        program_filter(coef_pair(UNITY, 0), coef_pair(0, 0), coef_pair(0, 0),
                       coef_pair(0, 0), '0);
        run_samples(300);
        src_idle_pct = 19;
        snk_idle_pct = 19;

        program_stable();
        run_samples(140);

        program_filter(CFG_DATA_W'({$urandom, $urandom}), CFG_DATA_W'({$urandom, $urandom}),
                       CFG_DATA_W'({$urandom, $urandom}), CFG_DATA_W'({$urandom, $urandom}),
                       COEF_BITS'($urandom));
        run_samples(140);

        program_filter(coef_pair(-UNITY, 0), coef_pair(0, 0),
                       coef_pair(0, rand_coef(8192)), coef_pair(0, 0), '0);
        run_samples(140);

        snk_idle_pct = 0;
        program_stable();
        run_samples(140);
        snk_idle_pct = 19;

        program_filter(coef_pair(COEF_MAX, COEF_MAX), coef_pair(COEF_MAX, COEF_MAX),
                       coef_pair(COEF_MAX, COEF_MAX), coef_pair(COEF_MAX, COEF_MAX),
                       COEF_BITS'(COEF_MAX));
        run_samples(140);

        program_stable();
        run_samples(140);

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

// ----- iir_order4_sample_filter_top.f -----
rtl/iir4_pkg.sv
rtl/iir4_coef_regs.sv
rtl/iir4_core.sv
rtl/iir_order4_sample_filter_top.sv
tb/sv/iir4_filter_checker.sv
tb/sv/tb.sv
